// ===== rtl/irtl_pkg.sv =====
// ----------------------------------------------------------------------------
// irtl_pkg
// Shared widths and codes for the IPv4 range table lookup.
// ----------------------------------------------------------------------------
package irtl_pkg;

  localparam int unsigned COUNT_W  = 17;
  localparam int unsigned SLOT_W   = 16;
  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned OFFSET_W = 24;
  localparam int unsigned LOC_W    = 25;
  localparam int unsigned WORD_W   = ADDR_W + OFFSET_W;

  localparam logic [LOC_W-1:0]   LOCATION_BIAS = LOC_W'(4);
  localparam logic [COUNT_W-1:0] COUNT_RESET   = COUNT_W'(1);

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_t;

endpackage

// ===== rtl/ip_range_table_lookup.sv =====
// ----------------------------------------------------------------------------
// ip_range_table_lookup
// Sorted IPv4 range table held in one memory, searched by binary search.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+------------------------------------
//  in_     | input     | in_valid / in_stall | kind, entry_slot/start/offset, query
//  out_    | output    | out_valid/out_stall | found, record_location, chosen_slot
//  cfg_    | input     | cfg_we              | cfg_wdata = entry_count
//
//  A load item writes the table memory at acceptance. A query makes one probe
//  per cycle through the single read port of the table.
//  Reset sets entry_count to 1; the table memory is not cleared.
//  A finished result waits in the output register while the next item is taken;
//  a query that finishes while it is still full holds in its last state.
// ----------------------------------------------------------------------------
module ip_range_table_lookup #(
  parameter int unsigned TABLE_DEPTH = 65536
) (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [irtl_pkg::SLOT_W-1:0]     in_entry_slot,
  input  logic [irtl_pkg::ADDR_W-1:0]     in_entry_start,
  input  logic [irtl_pkg::OFFSET_W-1:0]   in_entry_offset,
  input  logic [irtl_pkg::ADDR_W-1:0]     in_query_address,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_found,
  output logic [irtl_pkg::LOC_W-1:0]      out_record_location,
  output logic [irtl_pkg::SLOT_W-1:0]     out_chosen_slot,

  input  logic                            cfg_we,
  input  logic [irtl_pkg::COUNT_W-1:0]    cfg_wdata
);

  localparam int unsigned AW     = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned PICK_W = (AW > irtl_pkg::SLOT_W) ? AW : irtl_pkg::SLOT_W;
  localparam int unsigned SW     = PICK_W + 1;
  localparam int unsigned CW     = ((AW + 1) > irtl_pkg::COUNT_W) ? (AW + 1)
                                                                  : irtl_pkg::COUNT_W;
  localparam int unsigned WW     = irtl_pkg::WORD_W;
  localparam int unsigned OW     = irtl_pkg::OFFSET_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_ISSUE = 3'd1;
  localparam logic [2:0] S_STEP  = 3'd2;
  localparam logic [2:0] S_RD_HI = 3'd3;
  localparam logic [2:0] S_FIN   = 3'd4;

  logic [WW-1:0] mem [TABLE_DEPTH];
  logic [WW-1:0] rdata_r;
  logic [AW-1:0] raddr;
  logic          we;

  logic [2:0]                      state_r, state_nxt;
  logic [irtl_pkg::COUNT_W-1:0]    count_r;
  logic [AW-1:0]                   lo_r, lo_nxt;
  logic [AW-1:0]                   hi_r, hi_nxt;
  logic [AW-1:0]                   mid_r, mid_nxt;
  logic [irtl_pkg::ADDR_W-1:0]     q_r, q_nxt;
  logic [irtl_pkg::ADDR_W-1:0]     slo_r, slo_nxt;
  logic [OW-1:0]                   olo_r, olo_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic                            found_r, found_nxt;
  logic [irtl_pkg::LOC_W-1:0]      loc_r, loc_nxt;
  logic [irtl_pkg::SLOT_W-1:0]     slot_r, slot_nxt;

  logic                            accept;
  logic                            slot_ok;
  logic [CW-1:0]                   cnt_ext;
  logic [CW-1:0]                   cnt_eff;
  logic [AW-1:0]                   hi_init;
  logic [irtl_pkg::ADDR_W-1:0]     rd_start;
  logic [OW-1:0]                   rd_offset;
  logic                            go_up;
  logic [AW-1:0]                   mid_up, mid_dn;
  logic                            more_up, more_dn;
  logic                            out_free;
  logic                            pick_lo, pick_hi;
  logic [PICK_W-1:0]               pick_ext;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign slot_ok   = (SW'(in_entry_slot) < SW'(TABLE_DEPTH));
  assign we        = accept && (in_kind == irtl_pkg::KIND_LOAD) && slot_ok;
  assign rd_start  = rdata_r[WW-1:OW];
  assign rd_offset = rdata_r[OW-1:0];
  assign out_free  = !out_valid_r || !out_stall;

  always_comb begin
    cnt_ext = CW'(count_r);
    cnt_eff = (cnt_ext == '0) ? CW'(1) : cnt_ext;
    if (cnt_eff > CW'(TABLE_DEPTH)) begin
      cnt_eff = CW'(TABLE_DEPTH);
    end
    hi_init = AW'(cnt_eff - CW'(1));
  end

  // candidate next probes for both compare outcomes
  always_comb begin
    go_up   = (rd_start <= q_r);
    mid_up  = mid_r + ((hi_r - mid_r) >> 1);
    mid_dn  = lo_r + ((mid_r - lo_r) >> 1);
    more_up = ((hi_r - mid_r) > AW'(1));
    more_dn = ((mid_r - lo_r) > AW'(1));
  end

  always_comb begin
    pick_lo  = (q_r >= slo_r) && (q_r <= rd_start);
    pick_hi  = !pick_lo && (q_r >= rd_start);
    pick_ext = PICK_W'(pick_lo ? lo_r : hi_r);
  end

  always_comb begin
    state_nxt     = state_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    mid_nxt       = mid_r;
    q_nxt         = q_r;
    slo_nxt       = slo_r;
    olo_nxt       = olo_r;
    raddr         = lo_r;
    out_valid_nxt = out_valid_r && out_stall;
    found_nxt     = found_r;
    loc_nxt       = loc_r;
    slot_nxt      = slot_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_kind == irtl_pkg::KIND_QUERY)) begin
          lo_nxt    = '0;
          hi_nxt    = hi_init;
          q_nxt     = in_query_address;
          state_nxt = S_ISSUE;
        end
      end
      S_ISSUE: begin
        if ((hi_r - lo_r) > AW'(1)) begin
          mid_nxt   = lo_r + ((hi_r - lo_r) >> 1);
          raddr     = mid_nxt;
          state_nxt = S_STEP;
        end else begin
          raddr     = lo_r;
          state_nxt = S_RD_HI;
        end
      end
      S_STEP: begin
        if (go_up) begin
          lo_nxt = mid_r;
          if (more_up) begin
            mid_nxt = mid_up;
            raddr   = mid_up;
          end else begin
            raddr     = mid_r;
            state_nxt = S_RD_HI;
          end
        end else begin
          hi_nxt = mid_r;
          if (more_dn) begin
            mid_nxt = mid_dn;
            raddr   = mid_dn;
          end else begin
            raddr     = lo_r;
            state_nxt = S_RD_HI;
          end
        end
      end
      S_RD_HI: begin
        slo_nxt   = rd_start;
        olo_nxt   = rd_offset;
        raddr     = hi_r;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        raddr = hi_r;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          found_nxt     = pick_lo || pick_hi;
          if (pick_lo) begin
            loc_nxt  = irtl_pkg::LOC_W'(olo_r) + irtl_pkg::LOCATION_BIAS;
            slot_nxt = pick_ext[irtl_pkg::SLOT_W-1:0];
          end else if (pick_hi) begin
            loc_nxt  = irtl_pkg::LOC_W'(rd_offset) + irtl_pkg::LOCATION_BIAS;
            slot_nxt = pick_ext[irtl_pkg::SLOT_W-1:0];
          end else begin
            loc_nxt  = '0;
            slot_nxt = '0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[AW'(in_entry_slot)] <= {in_entry_start, in_entry_offset};
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= irtl_pkg::COUNT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        count_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    q_r     <= q_nxt;
    slo_r   <= slo_nxt;
    olo_r   <= olo_nxt;
    found_r <= found_nxt;
    loc_r   <= loc_nxt;
    slot_r  <= slot_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_found           = found_r;
  assign out_record_location = loc_r;
  assign out_chosen_slot     = slot_r;

endmodule

// ===== rtl/irtl_checker.sv =====
// ----------------------------------------------------------------------------
// irtl_checker
// Port-level checks on the result channel of the range table lookup.
// ----------------------------------------------------------------------------
module irtl_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_found,
  input logic [irtl_pkg::LOC_W-1:0]    out_record_location,
  input logic [irtl_pkg::SLOT_W-1:0]   out_chosen_slot
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_found) &&
      $stable(out_record_location) && $stable(out_chosen_slot))
    else $error("stalled result item changed");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> (out_record_location == '0) && (out_chosen_slot == '0))
    else $error("not-found item carries nonzero fields");

  a_hit_bias: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_record_location >= irtl_pkg::LOCATION_BIAS))
    else $error("found item location below bias");

  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind ip_range_table_lookup irtl_checker u_irtl_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_found           (out_found),
  .out_record_location (out_record_location),
  .out_chosen_slot     (out_chosen_slot)
);

// ===== tb/ip_range_table_lookup_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ip_range_table_lookup_test
// Loads sorted, unsorted and sparse range tables, runs address lookups against
// them at several entry counts and compares every result with a local
// prediction of the binary search, under random source and sink idling.
// ----------------------------------------------------------------------------
module ip_range_table_lookup_test;

  localparam int unsigned TABLE_DEPTH    = 65536;
  localparam int unsigned RESET_CYCLES   = 5;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned HOLD_CYCLES    = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned BUSY_PCT       = 56;
  localparam int unsigned QUIET_PCT      = 12;
  localparam int unsigned REPORT_LIMIT   = 100;

  typedef enum {SLOW_SINK, SLOW_SOURCE, FULL_RATE} traffic_t;

  typedef struct packed {
    logic                        found;
    logic [irtl_pkg::LOC_W-1:0]  location;
    logic [irtl_pkg::SLOT_W-1:0] slot;
  } lookup_result_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_kind = irtl_pkg::KIND_LOAD;
  logic [irtl_pkg::SLOT_W-1:0]   in_entry_slot = '0;
  logic [irtl_pkg::ADDR_W-1:0]   in_entry_start = '0;
  logic [irtl_pkg::OFFSET_W-1:0] in_entry_offset = '0;
  logic [irtl_pkg::ADDR_W-1:0]   in_query_address = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          out_found;
  logic [irtl_pkg::LOC_W-1:0]    out_record_location;
  logic [irtl_pkg::SLOT_W-1:0]   out_chosen_slot;
  logic                          cfg_we = 1'b0;
  logic [irtl_pkg::COUNT_W-1:0]  cfg_wdata = '0;

  logic [irtl_pkg::ADDR_W-1:0]   range_start [TABLE_DEPTH];
  logic [irtl_pkg::OFFSET_W-1:0] range_offset [TABLE_DEPTH];
  bit                            slot_loaded [TABLE_DEPTH];
  logic [irtl_pkg::COUNT_W-1:0]  table_count = irtl_pkg::COUNT_RESET;
  lookup_result_t                pending_results [$];

  traffic_t    traffic = SLOW_SINK;
  int unsigned hold_request = 0;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned loads_sent = 0;
  int unsigned queries_sent = 0;
  int unsigned misses_sent = 0;

  ip_range_table_lookup #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_kind             (in_kind),
    .in_entry_slot       (in_entry_slot),
    .in_entry_start      (in_entry_start),
    .in_entry_offset     (in_entry_offset),
    .in_query_address    (in_query_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_found           (out_found),
    .out_record_location (out_record_location),
    .out_chosen_slot     (out_chosen_slot),
    .cfg_we              (cfg_we),
    .cfg_wdata           (cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int unsigned effective_count();
    if (table_count == 0) return 1;
    if (table_count > TABLE_DEPTH) return TABLE_DEPTH;
    return table_count;
  endfunction

  function automatic lookup_result_t search_table(input logic [irtl_pkg::ADDR_W-1:0] addr);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lookup_result_t r;
    lo = 0;
    hi = effective_count() - 1;
    r = '0;
    while (hi > lo + 1) begin
      mid = lo + (hi - lo) / 2;
      if (range_start[mid] <= addr) lo = mid;
      else hi = mid;
    end
    if (addr >= range_start[lo] && addr <= range_start[hi]) begin
      r.found = 1'b1;
      r.slot = irtl_pkg::SLOT_W'(lo);
    end else if (addr >= range_start[hi]) begin
      r.found = 1'b1;
      r.slot = irtl_pkg::SLOT_W'(hi);
    end
    if (r.found) begin
      r.location = irtl_pkg::LOC_W'(range_offset[r.slot]) + irtl_pkg::LOCATION_BIAS;
    end
    return r;
  endfunction

  function automatic logic [irtl_pkg::ADDR_W-1:0] sparse_start(input int unsigned slot);
    return {slot[15:0], 16'h1000};
  endfunction

  function automatic logic [irtl_pkg::ADDR_W-1:0] pick_query(input int unsigned depth);
    logic [irtl_pkg::ADDR_W-1:0] base;
    base = range_start[$urandom_range(depth - 1)];
    case ($urandom_range(5))
      0: return $urandom;
      1: return (range_start[0] == 0) ? '0 : $urandom_range(range_start[0] - 1, 0);
      2: return base - 1;
      3: return base + 1;
      4: return base + $urandom_range(255);
      default: return base;
    endcase
  endfunction

  task automatic send_item(input irtl_pkg::kind_t kind,
                           input logic [irtl_pkg::SLOT_W-1:0] slot,
                           input logic [irtl_pkg::ADDR_W-1:0] start,
                           input logic [irtl_pkg::OFFSET_W-1:0] offset,
                           input logic [irtl_pkg::ADDR_W-1:0] addr);
    int unsigned idle_pct;
    lookup_result_t r;
    idle_pct = (traffic == SLOW_SINK) ? QUIET_PCT : (traffic == SLOW_SOURCE) ? BUSY_PCT : 0;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_entry_slot <= slot;
    in_entry_start <= start;
    in_entry_offset <= offset;
    in_query_address <= addr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == irtl_pkg::KIND_LOAD) begin
      range_start[slot] = start;
      range_offset[slot] = offset;
      slot_loaded[slot] = 1'b1;
      loads_sent++;
    end else begin
      r = search_table(addr);
      pending_results.push_back(r);
      queries_sent++;
      if (!r.found) misses_sent++;
    end
  endtask

  task automatic send_load(input logic [irtl_pkg::SLOT_W-1:0] slot,
                           input logic [irtl_pkg::ADDR_W-1:0] start,
                           input logic [irtl_pkg::OFFSET_W-1:0] offset);
    send_item(irtl_pkg::KIND_LOAD, slot, start, offset, $urandom);
  endtask

  task automatic send_query(input logic [irtl_pkg::ADDR_W-1:0] addr);
    send_item(irtl_pkg::KIND_QUERY, irtl_pkg::SLOT_W'($urandom), $urandom,
              irtl_pkg::OFFSET_W'($urandom), addr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_count(input logic [irtl_pkg::COUNT_W-1:0] value);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    table_count = value;
  endtask

  // Load the search path of addr in a sparse sorted table, then look it up.
  task automatic reach_query(input logic [irtl_pkg::ADDR_W-1:0] addr);
    int unsigned probes [$];
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    lo = 0;
    hi = effective_count() - 1;
    probes.push_back(lo);
    probes.push_back(hi);
    while (hi > lo + 1) begin
      mid = lo + (hi - lo) / 2;
      probes.push_back(mid);
      if (sparse_start(mid) <= addr) lo = mid;
      else hi = mid;
    end
    foreach (probes[i])
      if (!slot_loaded[probes[i]] || range_start[probes[i]] != sparse_start(probes[i]))
        send_load(irtl_pkg::SLOT_W'(probes[i]), sparse_start(probes[i]),
                  irtl_pkg::OFFSET_W'($urandom));
    send_query(addr);
  endtask

  task automatic test_directed();
    traffic = SLOW_SINK;
    send_load(16'd0, 32'h0A00_0000, 24'h00_0000);
    send_query(32'h0A00_0000);
    send_query(32'h09FF_FFFF);
    send_query(32'hFFFF_FFFF);
    send_query(32'h0000_0000);
    write_count(irtl_pkg::COUNT_W'(4));
    send_load(16'd0, 32'h0000_0000, 24'h00_0000);
    send_load(16'd1, 32'h4000_0000, 24'hFF_FFFF);
    send_load(16'd2, 32'h8000_0000, 24'h12_3456);
    send_load(16'd3, 32'hFFFF_FFFF, 24'h80_0000);
    send_query(32'h0000_0000);
    send_query(32'h3FFF_FFFF);
    send_query(32'h4000_0000);
    send_query(32'hFFFF_FFFE);
    send_query(32'hFFFF_FFFF);
    // break the ordering
    send_load(16'd1, 32'hF000_0000, 24'h00_0001);
    send_query(32'h5000_0000);
    send_query(32'hF000_0000);
  endtask

  task automatic test_count_clamp();
    write_count('0);
    send_load(16'd0, 32'h8000_0000, 24'h00_0010);
    send_query(32'h7FFF_FFFF);
    send_query(32'h8000_0000);
    send_query(32'hFFFF_FFFF);
  endtask

  task automatic test_random_lookups(input traffic_t mode, input int unsigned budget);
    int unsigned sent;
    int unsigned cfg_value;
    int unsigned depth;
    int unsigned dup;
    logic [irtl_pkg::ADDR_W-1:0] starts [$];
    traffic = mode;
    sent = 0;
    while (sent < budget) begin
      case ($urandom_range(7))
        0: cfg_value = 0;
        1: cfg_value = 1;
        2: cfg_value = 2;
        default: cfg_value = $urandom_range(48, 3);
      endcase
      write_count(irtl_pkg::COUNT_W'(cfg_value));
      depth = effective_count();
      starts.delete();
      repeat (depth) starts.push_back($urandom);
      if ($urandom_range(4) != 0) starts.sort();
      if (depth > 1 && $urandom_range(3) == 0) begin
        dup = $urandom_range(depth - 1, 1);
        starts[dup] = starts[dup - 1];
      end
      foreach (starts[i])
        send_load(irtl_pkg::SLOT_W'(i), starts[i], irtl_pkg::OFFSET_W'($urandom));
      sent += depth;
      repeat ($urandom_range(20, 4)) begin
        case ($urandom_range(13))
          0: send_load(irtl_pkg::SLOT_W'($urandom_range(depth - 1)), $urandom,
                       irtl_pkg::OFFSET_W'($urandom));
          1: send_load(irtl_pkg::SLOT_W'($urandom), $urandom, irtl_pkg::OFFSET_W'($urandom));
          default: send_query(pick_query(depth));
        endcase
        sent++;
      end
    end
  endtask

  task automatic test_backpressure();
    int unsigned depth;
    traffic = FULL_RATE;
    depth = effective_count();
    hold_request++;
    repeat (40) send_query(pick_query(depth));
  endtask

  task automatic test_full_depth();
    traffic = FULL_RATE;
    write_count(irtl_pkg::COUNT_W'(TABLE_DEPTH));
    reach_query(32'h0000_0000);
    reach_query(32'hFFFF_FFFF);
    reach_query(sparse_start(32'h8000));
    reach_query(sparse_start(32'h7FFF) - 1);
    repeat (6) reach_query($urandom);
    write_count('1);
    reach_query(sparse_start(0));
    repeat (4) reach_query($urandom);
  endtask

  always @(posedge clk) begin
    if (hold_seen != hold_request) begin
      hold_seen = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= $urandom_range(99) <
                   ((traffic == SLOW_SINK) ? BUSY_PCT : (traffic == SLOW_SOURCE) ? QUIET_PCT : 0);
    end
  end

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count < REPORT_LIMIT)
          $error("result with no lookup pending: found %0d location %0h slot %0d",
                 out_found, out_record_location, out_chosen_slot);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (out_found !== want.found) begin
          mismatch_count++;
          if (mismatch_count < REPORT_LIMIT)
            $error("found: expected %0d, actual %0d", want.found, out_found);
        end
        if (out_record_location !== want.location) begin
          mismatch_count++;
          if (mismatch_count < REPORT_LIMIT)
            $error("record_location: expected %0h, actual %0h", want.location,
                   out_record_location);
        end
        if (out_chosen_slot !== want.slot) begin
          mismatch_count++;
          if (mismatch_count < REPORT_LIMIT)
            $error("chosen_slot: expected %0d, actual %0d", want.slot, out_chosen_slot);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_count_clamp();
    test_random_lookups(SLOW_SINK, 290);
    test_random_lookups(SLOW_SOURCE, 290);
    test_random_lookups(FULL_RATE, 290);
    test_backpressure();
    test_full_depth();
    drain();
    $display("Covered %0d table loads and %0d lookups (%0d below the table), %0d results checked.",
             loads_sent, queries_sent, misses_sent, results_checked);
    $display("Entry counts ran from 0 to 131071, with a 65536-entry search and a long output hold.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
